[src/pt64_pkg.sv]
// package for prime_test_64: constants, types and the base table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pt64_pkg;
  localparam int unsigned NumBases = 7;
  localparam int unsigned NumSmall = 12;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mm_req_t;

  function automatic word_t base_value(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 64'd2;
      3'd1: v = 64'd325;
      3'd2: v = 64'd9375;
      3'd3: v = 64'd28178;
      3'd4: v = 64'd450775;
      3'd5: v = 64'd9780504;
      3'd6: v = 64'd1795265022;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] small_prime(input logic [3:0] idx);
    logic [5:0] v;
    case (idx)
      4'd0: v = 6'd2;
      4'd1: v = 6'd3;
      4'd2: v = 6'd5;
      4'd3: v = 6'd7;
      4'd4: v = 6'd11;
      4'd5: v = 6'd13;
      4'd6: v = 6'd17;
      4'd7: v = 6'd19;
      4'd8: v = 6'd23;
      4'd9: v = 6'd29;
      4'd10: v = 6'd31;
      4'd11: v = 6'd37;
      default: v = 6'd2;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[src/pt64_if.sv]
// valid/ready stream interfaces for candidates and results
// depends on pt64_pkg
`timescale 1ns / 1ps
`default_nettype none
interface pt64_cand_if;
  logic valid;
  logic ready;
  pt64_pkg::word_t candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface pt64_flag_if;
  logic valid;
  logic ready;
  logic prime_flag;
  modport source (output valid, output prime_flag, input ready);
  modport sink (input valid, input prime_flag, output ready);
endinterface
`default_nettype wire

[src/pt64_modmul.sv]
// shared shift-and-add modular multiplier, one bit of y per cycle
// depends on pt64_pkg
`timescale 1ns / 1ps
`default_nettype none
module pt64_modmul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pt64_pkg::mm_req_t req_i,
  input  wire pt64_pkg::word_t   m_i,
  output logic                   done_o,
  output pt64_pkg::word_t        p_o
);
  pt64_pkg::word_t acc_q, acc_d, x_q, y_q;
  logic [6:0] cnt_q;
  logic busy_q;
  logic [64:0] dbl, dbl_r, add, add_r;

  always_comb begin
    dbl = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add = dbl_r + {1'b0, x_q};
    add_r = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    acc_d = y_q[63] ? add_r[63:0] : dbl_r[63:0];
  end

  assign p_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      x_q <= req_i.x;
      y_q <= req_i.y;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q <= {y_q[62:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

[src/prime_test_64.sv]
// prime_test_64 top level: trial division and miller-rabin sequencer
// around one shared modular multiplier
// depends on pt64_pkg, pt64_if, pt64_modmul
//
// usage: a candidate transaction enters on cand when ready is high; one
// result transaction with prime_flag leaves on flag. the block handles one
// candidate at a time and is not ready until its result has been taken.
// trial division by 2..37 and base reduction use one restoring remainder
// step per cycle, with a check state after each divisor, so a tiny or
// small-factor input answers without any miller-rabin round. each
// miller-rabin base costs up to about 128 modular multiplications on the
// shared multiplier. reset returns the sequencer to idle with no result
// pending. when the receiver stalls, the result is held and no new
// candidate is taken.
`timescale 1ns / 1ps
`default_nettype none
module prime_test_64 (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pt64_cand_if.sink   cand,
  pt64_flag_if.source flag
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_TDIV  = 10'b0000000010,
    S_TCHK  = 10'b0000000100,
    S_SPLIT = 10'b0000001000,
    S_BRED  = 10'b0000010000,
    S_BCHK  = 10'b0000100000,
    S_PMUL  = 10'b0001000000,
    S_PCHK  = 10'b0010000000,
    S_SQR   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e st_q;
  pt64_pkg::word_t n_q, d_q, e_q, b_q, acc_q, rem_q, num_q, dvs_q;
  logic [6:0] s_q, r_q, bit_q;
  logic [3:0] pi_q;
  logic [2:0] bi_q;
  logic phase_q, wait_q, flag_q;
  pt64_pkg::mm_req_t req;
  logic mm_done;
  pt64_pkg::word_t mm_p;
  logic [64:0] sh;
  pt64_pkg::word_t nm1;

  assign nm1 = n_q - 64'd1;
  assign sh = {rem_q, num_q[63]};

  pt64_modmul u_mm (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .m_i(n_q),
    .done_o(mm_done), .p_o(mm_p)
  );

  assign cand.ready = (st_q == S_IDLE);
  assign flag.valid = (st_q == S_OUT);
  assign flag.prime_flag = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      req <= '0;
      wait_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: if (cand.valid) begin
          n_q <= cand.candidate;
          if (cand.candidate < 64'd2) begin
            flag_q <= 1'b0;
            st_q <= S_OUT;
          end else begin
            pi_q <= '0;
            num_q <= cand.candidate;
            rem_q <= '0;
            dvs_q <= {58'd0, pt64_pkg::small_prime(4'd0)};
            bit_q <= '0;
            st_q <= S_TDIV;
          end
        end
        S_TDIV, S_BRED: begin
          rem_q <= (sh >= {1'b0, dvs_q}) ? 64'(sh - {1'b0, dvs_q}) : sh[63:0];
          num_q <= {num_q[62:0], 1'b0};
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'd63) st_q <= (st_q == S_TDIV) ? S_TCHK : S_BCHK;
        end
        S_TCHK: begin
          if (rem_q == 64'd0) begin
            flag_q <= (n_q == dvs_q);
            st_q <= S_OUT;
          end else if (pi_q == 4'(pt64_pkg::NumSmall - 1)) begin
            d_q <= nm1;
            s_q <= '0;
            st_q <= S_SPLIT;
          end else begin
            pi_q <= pi_q + 4'd1;
            dvs_q <= {58'd0, pt64_pkg::small_prime(pi_q + 4'd1)};
            num_q <= n_q;
            rem_q <= '0;
            bit_q <= '0;
            st_q <= S_TDIV;
          end
        end
        S_SPLIT: begin
          if (d_q[0]) begin
            bi_q <= '0;
            num_q <= pt64_pkg::base_value(3'd0);
            dvs_q <= n_q;
            rem_q <= '0;
            bit_q <= '0;
            st_q <= S_BRED;
          end else begin
            d_q <= {1'b0, d_q[63:1]};
            s_q <= s_q + 7'd1;
          end
        end
        S_BCHK: begin
          if (rem_q == 64'd0) begin
            st_q <= S_PCHK;
            acc_q <= 64'd1;
            e_q <= '0;
            wait_q <= 1'b0;
          end else begin
            b_q <= rem_q;
            e_q <= d_q;
            acc_q <= 64'd1;
            phase_q <= 1'b0;
            wait_q <= 1'b0;
            st_q <= S_PMUL;
          end
        end
        S_PMUL: begin
          if (!wait_q) begin
            if (e_q == 64'd0) begin
              st_q <= S_PCHK;
            end else if (!phase_q && e_q[0]) begin
              req <= '{start: 1'b1, x: acc_q, y: b_q};
              wait_q <= 1'b1;
            end else begin
              phase_q <= 1'b1;
              req <= '{start: 1'b1, x: b_q, y: b_q};
              wait_q <= 1'b1;
            end
          end else begin
            req.start <= 1'b0;
            if (mm_done) begin
              wait_q <= 1'b0;
              if (!phase_q) begin
                acc_q <= mm_p;
                phase_q <= 1'b1;
              end else begin
                b_q <= mm_p;
                e_q <= {1'b0, e_q[63:1]};
                phase_q <= 1'b0;
              end
            end
          end
        end
        S_PCHK: begin
          if (rem_q == 64'd0 || acc_q == 64'd1 || acc_q == nm1) begin
            if (bi_q == 3'(pt64_pkg::NumBases - 1)) begin
              flag_q <= 1'b1;
              st_q <= S_OUT;
            end else begin
              bi_q <= bi_q + 3'd1;
              num_q <= pt64_pkg::base_value(bi_q + 3'd1);
              rem_q <= '0;
              bit_q <= '0;
              st_q <= S_BRED;
            end
          end else begin
            r_q <= 7'd1;
            wait_q <= 1'b0;
            st_q <= S_SQR;
          end
        end
        S_SQR: begin
          if (!wait_q) begin
            if (r_q >= s_q) begin
              flag_q <= 1'b0;
              st_q <= S_OUT;
            end else begin
              req <= '{start: 1'b1, x: acc_q, y: acc_q};
              wait_q <= 1'b1;
            end
          end else begin
            req.start <= 1'b0;
            if (mm_done) begin
              wait_q <= 1'b0;
              acc_q <= mm_p;
              r_q <= r_q + 7'd1;
              if (mm_p == nm1) begin
                rem_q <= '0;
                st_q <= S_PCHK;
              end
            end
          end
        end
        S_OUT: if (flag.ready) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[test/prime_test_64_tb.sv]
// testbench for prime_test_64: directed and random candidates, random stalls
// predicts each flag with its own primality function; depends on pt64_pkg, pt64_if, prime_test_64
`timescale 1ns / 1ps
`default_nettype none
module prime_test_64_tb;
  typedef pt64_pkg::word_t word_t;

  localparam int unsigned NumRandom = 120;
  localparam int unsigned QuietFrom = 100;
  localparam int unsigned IdleLimit = 400000;
  localparam int unsigned LongHold = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pt64_cand_if cand ();
  pt64_flag_if flag ();

  prime_test_64 uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cand  (cand.sink),
    .flag  (flag.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic word_t mul_mod(word_t x, word_t y, word_t m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return word_t'(p % {64'd0, m});
  endfunction

  function automatic word_t pow_mod(word_t b, word_t e, word_t m);
    word_t acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit prime_check(word_t n);
    word_t divisors [12];
    word_t witnesses [7];
    word_t odd;
    word_t a;
    word_t x;
    int twos;
    bit comp;
    divisors = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    witnesses = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
    if (n < 2) return 1'b0;
    foreach (divisors[i]) begin
      if (n % divisors[i] == 0) return n == divisors[i];
    end
    odd = n - 1;
    twos = 0;
    while (!odd[0]) begin
      twos++;
      odd = odd >> 1;
    end
    foreach (witnesses[i]) begin
      a = witnesses[i] % n;
      if (a == 0) continue;
      x = pow_mod(a, odd, n);
      if (x == 1 || x == n - 1) continue;
      comp = 1'b1;
      for (int r = 1; r < twos; r++) begin
        x = mul_mod(x, x, n);
        if (x == n - 1) begin
          comp = 1'b0;
          break;
        end
      end
      if (comp) return 1'b0;
    end
    return 1'b1;
  endfunction

  class flag_board;
    bit pending [$];
    word_t cands [$];
    int errors;

    function void note(word_t c);
      pending = {pending, prime_check(c)};
      cands = {cands, c};
    endfunction

    function void check(logic got);
      bit want;
      word_t c;
      if (pending.size() == 0) begin
        $display("%0t: unexpected flag %b", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      c = cands.pop_front();
      if (got !== want) begin
        $display("%0t: candidate %0d expected %b actual %b", $time, c, want, got);
        errors++;
      end
    endfunction
  endclass

  flag_board board = new();
  bit quiet = 1'b0;
  bit hold_done = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  task automatic send_cand(word_t c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cand.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cand.valid <= 1'b1;
    cand.candidate <= c;
    do @(posedge clk_i); while (!cand.ready);
    board.note(c);
    sent++;
  endtask

  function automatic word_t random_cand();
    word_t v;
    int unsigned w;
    word_t plist [6];
    plist = '{64'd18446744073709551557, 64'd2305843009213693951, 64'd4294967291,
              64'd1000000007, 64'd65521, 64'd7919};
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        w = $urandom_range(6, 24);
        v = (v & ((64'd1 << w) - 1)) | 64'd1;
      end
      4, 5: v = v | 64'd1;
      6: v = {$urandom, $urandom};
      7: v = word_t'($urandom_range(2, 37)) * word_t'($urandom_range(1, 1000000));
      8: v = plist[$urandom_range(2, 5)];
      default: v = (v & 64'hffff) | 64'd1;
    endcase
    if ($urandom_range(0, 29) == 0) v = plist[$urandom_range(0, 1)];
    return v;
  endfunction

  initial begin
    word_t directed [$];
    directed = {64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd38, 64'd41, 64'd73,
                64'd193, 64'd14089, 64'd561, 64'd2047, 64'd3215031751,
                64'd341550071728321, 64'd2305843009213693951,
                64'd18446744073709551557, 64'hffffffffffffffff,
                64'd18446744030759878681, 64'h8000000000000000,
                64'd4294967291, 64'd1373653};
    cand.valid = 1'b0;
    cand.candidate = '0;
    flag.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_cand(directed[i]);
    for (int i = 0; i < NumRandom; i++) begin
      if (i >= QuietFrom) quiet = 1'b1;
      send_cand(random_cand());
    end
    cand.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("prime_test_64_tb OK");
    end else begin
      $display("prime_test_64_tb NOT OK");
    end
    $finish;
  end

  // receiver side stalls, with one long hold while the sender keeps offering
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent >= 8) begin
        hold_done = 1'b1;
        flag.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        flag.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk_i);
      end else begin
        flag.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && flag.valid && flag.ready) board.check(flag.prime_flag);
  end

  always @(posedge clk_i) begin
    if ((cand.valid && cand.ready) || (flag.valid && flag.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout", $time);
      $display("prime_test_64_tb NOT OK");
      $finish;
    end
  end
endmodule
`default_nettype wire
